### rtl/fmmcs_pkg.sv
package fmmcs_pkg;

    localparam int FRAME_WIDTH  = 80;
    localparam int FRAME_HEIGHT = 60;
    localparam int PIXELS       = FRAME_WIDTH * FRAME_HEIGHT;

    // counter holds 0..PIXELS, address 0..PIXELS-1
    localparam int CNT_W  = $clog2(PIXELS + 1);
    localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int SUM_W  = 16 + CNT_W;

    // mean by reciprocal multiplication, exact for any sum below 2^SUM_W
    localparam int MEAN_K   = SUM_W + $clog2(PIXELS);
    localparam int MEAN_M_W = SUM_W + 1;
    localparam int PROD_W   = SUM_W + MEAN_M_W;
    localparam longint unsigned MEAN_M =
        ((64'd1 << MEAN_K) + longint'(PIXELS) - 1) / longint'(PIXELS);

    // divider: 16 quotient bits, dividend below divisor * 2^16
    localparam int QBITS  = 16;
    localparam int QCNT_W = $clog2(QBITS + 1);
    localparam int DIV_W  = (CNT_W > 17) ? CNT_W : 17;
    localparam int DVD_W  = DIV_W + QBITS;

    localparam logic [15:0] MIN_SPAN_RESET = 16'd200;
    localparam logic [16:0] FULL_SCALE     = 17'd65535;
    localparam logic [15:0] OUT_OFFSET     = 16'h8000;

    typedef struct packed {
        logic        opcode;
        logic [15:0] pixel_value;
    } pix_item_t;

    typedef struct packed {
        logic signed [15:0] scaled_pixel;
        logic               last_of_frame;
    } res_item_t;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QBITS-1:0] quotient;
    } div_rsp_t;

endpackage

### rtl/frame_min_max_contrast_stretch.sv
// load item: accepted whenever idle; after the frame's last pixel the block
// stalls through ST_MEAN (mean, reciprocal multiply) and ST_SETL (range)
// readout item: ST_READ starts the bit-serial divider, ST_DIV waits for it, ST_OUT
// issues the result when free; input stalls till then (zero span skips ST_DIV)
// reset: control and statistics cleared, min_span back to 200, the frame
// store is not cleared (readout only reads entries of the current frame)
module frame_min_max_contrast_stretch (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  fmmcs_pkg::pix_item_t pix_item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output fmmcs_pkg::res_item_t res_item,
    input  logic                 min_span_we,
    input  logic [15:0]          min_span_wdata
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MEAN = 6'b000010,
        ST_SETL = 6'b000100,
        ST_READ = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]                  min_reg, min_next;
    logic [15:0]                  max_reg, max_next;
    logic [fmmcs_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [fmmcs_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                         phase_reg, phase_next;
    logic [15:0]                  low_reg, low_next;
    logic [16:0]                  span_reg, span_next;
    logic [15:0]                  min_span_reg;
    logic [15:0]                  mean_reg, mean_next;
    logic                         last_reg, last_next;
    logic [15:0]                  res_reg, res_next;
    logic                         res_valid_reg, res_valid_next;
    fmmcs_pkg::res_item_t         res_item_reg, res_item_next;

    logic [15:0]                  mem [fmmcs_pkg::PIXELS];
    logic [15:0]                  rd_q;
    logic                         mem_we;
    logic                         mem_re;
    logic [fmmcs_pkg::ADDR_W-1:0] addr;

    fmmcs_pkg::div_req_t          div_req;
    fmmcs_pkg::div_rsp_t          div_rsp;

    logic                         accept;
    logic                         out_free;
    logic [fmmcs_pkg::CNT_W-1:0]  idx_inc;
    logic [fmmcs_pkg::PROD_W-1:0] mean_prod;

    logic [16:0] s_mean, s_lo, s_hi, s_up, s_down, s_hi2, s_lo2;
    logic [17:0] s_sum;
    logic [16:0] s_mid, s_half, s_top;
    logic [15:0] off;

    assign pix_stall = (state_reg != ST_IDLE);
    assign accept    = pix_valid && !pix_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign idx_inc   = idx_reg + 1'b1;
    assign addr      = idx_reg[fmmcs_pkg::ADDR_W-1:0];
    assign mem_we    = accept && !phase_reg && (pix_item.opcode == fmmcs_pkg::OP_LOAD);
    assign mem_re    = accept && phase_reg && (pix_item.opcode == fmmcs_pkg::OP_READ);
    assign mean_prod = fmmcs_pkg::PROD_W'(sum_reg) * fmmcs_pkg::PROD_W'(fmmcs_pkg::MEAN_M);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr] <= pix_item.pixel_value;
        end
        if (mem_re)
        begin
            rd_q <= mem[addr];
        end
    end

    // range settle from the mean; mean always lies within [min, max]
    always_comb
    begin
        s_mean = {1'b0, mean_reg};
        s_lo   = {1'b0, min_reg};
        s_hi   = {1'b0, max_reg};
        s_up   = s_hi - s_mean;
        s_down = s_mean - s_lo;
        if (s_up > s_down)
        begin
            s_lo = (s_up > s_mean) ? 17'd0 : s_mean - s_up;
        end
        else
        begin
            s_hi = s_mean + s_down;
            if (s_hi > fmmcs_pkg::FULL_SCALE)
            begin
                s_hi = fmmcs_pkg::FULL_SCALE;
            end
        end
        s_sum  = {1'b0, s_hi} + {1'b0, s_lo};
        s_mid  = s_sum[17:1];
        s_half = {2'b00, min_span_reg[15:1]};
        s_top  = s_mid + s_half;
        s_hi2  = s_hi;
        s_lo2  = s_lo;
        if ((s_hi - s_lo) < {1'b0, min_span_reg})
        begin
            s_hi2 = (s_top > fmmcs_pkg::FULL_SCALE) ? fmmcs_pkg::FULL_SCALE : s_top;
            s_lo2 = (s_half > s_mid) ? 17'd0 : s_mid - s_half;
        end
    end

    // offset into the range, clamped to [0, span]
    always_comb
    begin
        off = (rd_q > low_reg) ? rd_q - low_reg : 16'd0;
        if ({1'b0, off} > span_reg)
        begin
            off = span_reg[15:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        low_next       = low_reg;
        span_next      = span_reg;
        mean_next      = mean_reg;
        last_next      = last_reg;
        res_next       = res_reg;
        res_item_next  = res_item_reg;
        res_valid_next = res_valid_reg && res_stall;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !phase_reg && pix_item.opcode == fmmcs_pkg::OP_LOAD)
                begin
                    if (pix_item.pixel_value < min_reg)
                    begin
                        min_next = pix_item.pixel_value;
                    end
                    if (pix_item.pixel_value > max_reg)
                    begin
                        max_next = pix_item.pixel_value;
                    end
                    sum_next = sum_reg + fmmcs_pkg::SUM_W'(pix_item.pixel_value);
                    idx_next = idx_inc;
                    if (idx_inc == fmmcs_pkg::CNT_W'(fmmcs_pkg::PIXELS))
                    begin
                        idx_next   = '0;
                        state_next = ST_MEAN;
                    end
                end
                else if (mem_re)
                begin
                    idx_next   = idx_inc;
                    last_next  = (idx_inc == fmmcs_pkg::CNT_W'(fmmcs_pkg::PIXELS));
                    state_next = ST_READ;
                    if (idx_inc == fmmcs_pkg::CNT_W'(fmmcs_pkg::PIXELS))
                    begin
                        min_next   = 16'hFFFF;
                        max_next   = '0;
                        sum_next   = '0;
                        idx_next   = '0;
                        phase_next = 1'b0;
                    end
                end
            end
            ST_MEAN:
            begin
                mean_next  = mean_prod[fmmcs_pkg::MEAN_K +: 16];
                state_next = ST_SETL;
            end
            ST_SETL:
            begin
                low_next   = s_lo2[15:0];
                span_next  = s_hi2 - s_lo2;
                phase_next = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (span_reg == 17'd0)
                begin
                    res_next   = 16'd0 - fmmcs_pkg::OUT_OFFSET;
                    state_next = ST_OUT;
                end
                else
                begin
                    // off * 65535 as (off << 16) - off
                    div_req.start    = 1'b1;
                    div_req.dividend = fmmcs_pkg::DVD_W'({off, 16'h0000})
                                     - fmmcs_pkg::DVD_W'(off);
                    div_req.divisor  = fmmcs_pkg::DIV_W'(span_reg);
                    state_next       = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_next   = div_rsp.quotient - fmmcs_pkg::OUT_OFFSET;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    res_item_next.scaled_pixel  = $signed(res_reg);
                    res_item_next.last_of_frame = last_reg;
                    res_valid_next              = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    fmmcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_reg       <= 16'hFFFF;
            max_reg       <= '0;
            sum_reg       <= '0;
            idx_reg       <= '0;
            phase_reg     <= 1'b0;
            low_reg       <= '0;
            span_reg      <= '0;
            min_span_reg  <= fmmcs_pkg::MIN_SPAN_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            low_reg       <= low_next;
            span_reg      <= span_next;
            res_valid_reg <= res_valid_next;
            if (min_span_we)
            begin
                min_span_reg <= min_span_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg     <= mean_next;
        last_reg     <= last_next;
        res_reg      <= res_next;
        res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

### rtl/fmmcs_div.sv
module fmmcs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  fmmcs_pkg::div_req_t req,
    output fmmcs_pkg::div_rsp_t rsp
);

    logic [fmmcs_pkg::DIV_W-1:0]  rem_reg, rem_next;
    logic [fmmcs_pkg::DIV_W-1:0]  dvs_reg, dvs_next;
    logic [fmmcs_pkg::QBITS-1:0]  q_reg, q_next;
    logic [fmmcs_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [fmmcs_pkg::DIV_W:0]    rem2;
    logic [fmmcs_pkg::DIV_W:0]    diff;
    logic                         ge;

    assign rem2 = {rem_reg, q_reg[fmmcs_pkg::QBITS-1]};
    assign diff = rem2 - {1'b0, dvs_reg};
    assign ge   = (rem2 >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.dividend[fmmcs_pkg::DVD_W-1:fmmcs_pkg::QBITS];
            q_next    = req.dividend[fmmcs_pkg::QBITS-1:0];
            dvs_next  = req.divisor;
            cnt_next  = fmmcs_pkg::QCNT_W'(fmmcs_pkg::QBITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in where dividend bits shift out
            rem_next = ge ? diff[fmmcs_pkg::DIV_W-1:0] : rem2[fmmcs_pkg::DIV_W-1:0];
            q_next   = {q_reg[fmmcs_pkg::QBITS-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == fmmcs_pkg::QCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

### rtl/fmmcs_checker.sv
module fmmcs_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 pix_valid,
    input logic                 pix_stall,
    input fmmcs_pkg::pix_item_t pix_item,
    input logic                 res_valid,
    input logic                 res_stall,
    input fmmcs_pkg::res_item_t res_item
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("stalled result changed");

    // a new result comes out of the busy sequence, never while input is open
    a_res_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pix_stall))
        else $error("result appeared without a busy cycle before it");

    // handshake outputs are always known out of reset
    a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({pix_stall, res_valid}))
        else $error("stall or valid unknown");

    // a valid result carries a known item
    a_res_known: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !$isunknown(res_item))
        else $error("valid result item unknown");

    // an offered input item is known
    a_pix_known: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> !$isunknown(pix_item))
        else $error("offered input item unknown");

endmodule

bind frame_min_max_contrast_stretch fmmcs_checker u_fmmcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_item  (pix_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    class stretch_scoreboard;
        logic [15:0] frame_mem [fmmcs_pkg::PIXELS];
        int unsigned pix_min;
        int unsigned pix_max;
        longint unsigned pix_sum;
        int unsigned pix_cnt;
        bit reading;
        int unsigned win_low;
        int unsigned win_span;
        logic [15:0] span_floor;
        fmmcs_pkg::res_item_t pending [$];
        int errors;

        function new();
            span_floor = fmmcs_pkg::MIN_SPAN_RESET;
            win_low = 0;
            win_span = 0;
            reading = 0;
            errors = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            pix_min = 65535;
            pix_max = 0;
            pix_sum = 0;
            pix_cnt = 0;
        endfunction

        function void settle_window();
            int unsigned avg;
            int unsigned lo;
            int unsigned hi;
            int unsigned up;
            int unsigned down;
            int unsigned mid;
            int unsigned half;
            avg = int'(pix_sum / fmmcs_pkg::PIXELS);
            lo = pix_min;
            hi = pix_max;
            up = hi - avg;
            down = avg - lo;
            if (up > down)
                lo = (up > avg) ? 0 : avg - up;
            else
            begin
                hi = avg + down;
                if (hi > 65535)
                    hi = 65535;
            end
            if (hi - lo < span_floor)
            begin
                mid = (hi + lo) >> 1;
                half = span_floor >> 1;
                hi = mid + half;
                if (hi > 65535)
                    hi = 65535;
                lo = (half > mid) ? 0 : mid - half;
            end
            win_low = lo;
            win_span = hi - lo;
        endfunction

        function void note_input(fmmcs_pkg::pix_item_t it);
            int unsigned p;
            int unsigned off;
            int unsigned stretched;
            fmmcs_pkg::res_item_t r;
            if (!reading)
            begin
                if (it.opcode != fmmcs_pkg::OP_LOAD)
                    return;
                frame_mem[pix_cnt] = it.pixel_value;
                if (it.pixel_value < pix_min)
                    pix_min = it.pixel_value;
                if (it.pixel_value > pix_max)
                    pix_max = it.pixel_value;
                pix_sum += it.pixel_value;
                pix_cnt++;
                if (pix_cnt >= fmmcs_pkg::PIXELS)
                begin
                    settle_window();
                    pix_cnt = 0;
                    reading = 1;
                end
                return;
            end
            if (it.opcode != fmmcs_pkg::OP_READ)
                return;
            p = frame_mem[pix_cnt];
            stretched = 0;
            if (win_span != 0)
            begin
                off = (p > win_low) ? p - win_low : 0;
                if (off > win_span)
                    off = win_span;
                stretched = int'((longint'(off) * 65535) / win_span);
            end
            r.scaled_pixel = 16'(stretched - 32768);
            pix_cnt++;
            r.last_of_frame = (pix_cnt >= fmmcs_pkg::PIXELS);
            pending.push_back(r);
            if (r.last_of_frame)
            begin
                clear_stats();
                reading = 0;
            end
        endfunction

        function void check_result(fmmcs_pkg::res_item_t got);
            fmmcs_pkg::res_item_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result scaled %0d last %0b", $time,
                         got.scaled_pixel, got.last_of_frame);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.scaled_pixel !== exp_r.scaled_pixel)
            begin
                $display("%0t: scaled_pixel expected %0d actual %0d", $time,
                         exp_r.scaled_pixel, got.scaled_pixel);
                errors++;
            end
            if (got.last_of_frame !== exp_r.last_of_frame)
            begin
                $display("%0t: last_of_frame expected %0b actual %0b", $time,
                         exp_r.last_of_frame, got.last_of_frame);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic pix_valid = 1'b0;
    logic pix_stall;
    fmmcs_pkg::pix_item_t pix_item = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    fmmcs_pkg::res_item_t res_item;
    logic min_span_we = 1'b0;
    logic [15:0] min_span_wdata = '0;

    stretch_scoreboard sb = new();
    int result_count = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    int run_left = 0;
    bit hold_done = 0;

    frame_min_max_contrast_stretch i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_valid      (pix_valid),
        .pix_stall      (pix_stall),
        .pix_item       (pix_item),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_item       (res_item),
        .min_span_we    (min_span_we),
        .min_span_wdata (min_span_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver: random stalls, one long hold-off partway into the first readout
    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
        begin
            sb.check_result(res_item);
            result_count++;
        end
        if (!hold_done && result_count == 100)
        begin
            hold_done = 1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else if (run_left > 0)
        begin
            run_left--;
            res_stall <= 1'b0;
        end
        else
        begin
            res_stall <= ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                run_left = $urandom_range(20, 200);
            else if ($urandom_range(0, 30) == 0)
                hold_left = $urandom_range(10, 60);
        end
    end

    always @(posedge clk)
    begin
        if ((pix_valid && !pix_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000)
        begin
            $display("frame_min_max_contrast_stretch test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 97)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] pick_pixel(int mode, int n);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0: return 16'(30000 + $urandom_range(0, 50));
            1: return 16'd1234;
            2: return 16'($urandom_range(0, 20));
            3: return (r < 3) ? 16'hffff : 16'($urandom_range(0, 5));
            4: return (r < 3) ? 16'h0000 : 16'(65530 + $urandom_range(0, 5));
            5: return 16'(65500 + $urandom_range(0, 35));
            default:
            begin
                if (n == 0)
                    return 16'h0000;
                if (n == 1)
                    return 16'hffff;
                return 16'($urandom);
            end
        endcase
    endfunction

    task automatic send_item(fmmcs_pkg::pix_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_item <= it;
        do
            @(posedge clk);
        while (pix_stall);
        sb.note_input(it);
    endtask

    task automatic wait_drained();
        pix_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_min_span(logic [15:0] v);
        min_span_we <= 1'b1;
        min_span_wdata <= v;
        @(posedge clk);
        min_span_we <= 1'b0;
        sb.span_floor = v;
        @(posedge clk);
    endtask

    task automatic run_frame(int mode, bit mid_pause);
        fmmcs_pkg::pix_item_t it;
        int n;
        int reads;
        n = 0;
        reads = 0;
        while (!sb.reading)
        begin
            // stray read requests while loading are ignored
            if ($urandom_range(0, 19) == 0)
                it = '{opcode: fmmcs_pkg::OP_READ, pixel_value: 16'($urandom)};
            else
            begin
                it = '{opcode: fmmcs_pkg::OP_LOAD, pixel_value: pick_pixel(mode, n)};
                n++;
            end
            send_item(it);
        end
        while (sb.reading)
        begin
            if ($urandom_range(0, 19) == 0)
                it = '{opcode: fmmcs_pkg::OP_LOAD, pixel_value: 16'($urandom)};
            else
            begin
                it = '{opcode: fmmcs_pkg::OP_READ, pixel_value: 16'($urandom)};
                reads++;
            end
            send_item(it);
            if (mid_pause && reads == 50)
            begin
                mid_pause = 0;
                wait_drained();
            end
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_frame(0, 0);           // reset min_span, narrow data -> window
        write_min_span(16'd0);
        run_frame(1, 1);           // flat frame, zero span
        write_min_span(16'hffff);
        run_frame(2, 0);           // widened window saturates low
        write_min_span(16'd1001);
        run_frame(3, 0);           // mirrored window saturates at zero
        write_min_span(16'd30001);
        run_frame(4, 0);           // mirrored window saturates at full scale
        run_frame(5, 0);           // odd window saturates at full scale
        write_min_span(16'($urandom));
        run_frame(6, 0);
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("frame_min_max_contrast_stretch test passed");
        else
            $display("frame_min_max_contrast_stretch test failed");
        $finish;
    end

endmodule
